// ===== rtl/core/efsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatcher package
// Shared widths, limits and the structs that travel along the server chain.
// ----------------------------------------------------------------------------
package efsd_pkg;

  localparam int IN_W   = 32;  // requested start and end times
  localparam int TIME_W = 48;  // server free times
  localparam int CNT_W  = 16;  // per-server job counts
  localparam int SRV_W  = 4;   // server index as reported on the result
  localparam int IDX_W  = 6;   // internal server index, covers up to 64 servers
  localparam int CFG_W  = 5;   // server_count register

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Search state handed from one server cell to the next
  typedef struct packed {
    logic              found;   // a server free by the start has been seen
    logic [IDX_W-1:0]  fidx;
    logic [CNT_W-1:0]  fcount;
    logic              mvalid;  // an earliest-free candidate has been seen
    logic [IDX_W-1:0]  midx;
    logic [TIME_W-1:0] mtime;
    logic [CNT_W-1:0]  mcount;
  } carry_t;

  // Write-back broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] ftime;
    logic [CNT_W-1:0]  count;
  } update_t;

endpackage

// ===== rtl/core/efsd_cell.sv =====
// ----------------------------------------------------------------------------
// Server cell
// Holds one server's free time and job count, folds itself into the search
// carry and registers the carry for the next cell.
// ----------------------------------------------------------------------------
module efsd_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       active,
  input  logic [efsd_pkg::IN_W-1:0]  start_time,
  input  efsd_pkg::carry_t           carry_in,
  output efsd_pkg::carry_t           carry_out,
  input  efsd_pkg::update_t          upd
);

  localparam logic [efsd_pkg::IDX_W-1:0] MY_IDX = efsd_pkg::IDX_W'(IDX);

  logic [efsd_pkg::TIME_W-1:0] free_time_r;
  logic [efsd_pkg::CNT_W-1:0]  job_count_r;
  efsd_pkg::carry_t            carry_r;
  efsd_pkg::carry_t            carry_nxt;
  logic [efsd_pkg::TIME_W-1:0] start_w;

  assign start_w = {{(efsd_pkg::TIME_W-efsd_pkg::IN_W){1'b0}}, start_time};

  always_comb begin
    carry_nxt = carry_in;
    if (active) begin
      if (!carry_in.found && (free_time_r <= start_w)) begin
        carry_nxt.found  = 1'b1;
        carry_nxt.fidx   = MY_IDX;
        carry_nxt.fcount = job_count_r;
      end
      // strict compare keeps the lowest index on equal free times
      if (!carry_in.mvalid || (free_time_r < carry_in.mtime)) begin
        carry_nxt.mvalid = 1'b1;
        carry_nxt.midx   = MY_IDX;
        carry_nxt.mtime  = free_time_r;
        carry_nxt.mcount = job_count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_time_r <= '0;
      job_count_r <= '0;
    end else if (upd.en && (upd.idx == MY_IDX)) begin
      free_time_r <= upd.ftime;
      job_count_r <= upd.count;
    end
  end

  assign carry_out = carry_r;

endmodule

// ===== rtl/core/earliest_free_server_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatcher
// Assigns each job to the lowest-index server free by its start, or else to
// the earliest-free server with a delayed start, and tracks the busiest one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one job request per transfer, start and end times.
//   Result channel out_*: one result per request, in request order.
//   cfg_wr_en/cfg_wr_data write server_count; write only while idle.
//   A request is taken only while no other request is in work. Its search
//   sweeps the server chain, one cell per cycle, then a commit updates the
//   chosen server; the length of the sweep is set by the length of the cell
//   chain.
//   The result sits in an output register, so the next request is accepted
//   while a result still waits. If the receiver stalls past the end of the
//   next search, the commit of that request waits until the output register
//   empties.
//   Reset clears all free times and job counts, the busiest-server record,
//   and sets server_count to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatcher #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // start_time [31:0], end_time [63:32]
  input  logic [63:0]                 in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // assigned_server [3:0], run_start [51:4], actual_end [99:52],
  // busiest_server [103:100], busiest_count [119:104], saturated [120], zero pad
  output logic [127:0]                out_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int CW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = efsd_pkg::IDX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [CW-1:0]                 sweep_cnt_r;
  logic [efsd_pkg::CFG_W-1:0]    server_count_r;
  logic [NW-1:0]                 n_eff;
  logic [efsd_pkg::IN_W-1:0]     start_r;
  logic [efsd_pkg::IN_W-1:0]     len_r;
  logic [efsd_pkg::IN_W-1:0]     in_start;
  logic [efsd_pkg::IN_W-1:0]     in_end;
  logic [efsd_pkg::IDX_W-1:0]    best_srv_r;
  logic [efsd_pkg::CNT_W-1:0]    best_cnt_r;

  efsd_pkg::carry_t              chain [MAX_SERVERS+1];
  efsd_pkg::carry_t              fin;
  efsd_pkg::update_t             upd;

  logic [efsd_pkg::IDX_W-1:0]    chosen;
  logic [efsd_pkg::CNT_W-1:0]    old_cnt;
  logic [efsd_pkg::CNT_W-1:0]    new_cnt;
  logic [efsd_pkg::TIME_W-1:0]   act_start;
  logic [efsd_pkg::TIME_W-1:0]   act_end;
  logic [efsd_pkg::TIME_W:0]     end_sum;
  logic                          time_sat;
  logic                          cnt_sat;
  logic                          best_take;
  logic                          commit;

  logic [efsd_pkg::SRV_W-1:0]    o_srv_r;
  logic [efsd_pkg::TIME_W-1:0]   o_start_r;
  logic [efsd_pkg::TIME_W-1:0]   o_end_r;
  logic [efsd_pkg::SRV_W-1:0]    o_best_srv_r;
  logic [efsd_pkg::CNT_W-1:0]    o_best_cnt_r;
  logic                          o_sat_r;
  logic                          out_valid_r;

  assign in_start  = in_tdata[31:0];
  assign in_end    = in_tdata[63:32];
  assign in_tready = (state_r == S_IDLE);

  // Servers in use: zero means one, clamp at the cell count
  always_comb begin
    n_eff = {{(NW-efsd_pkg::CFG_W){1'b0}}, server_count_r};
    if (n_eff == '0) begin
      n_eff = NW'(1);
    end else if (n_eff > NW'(MAX_SERVERS)) begin
      n_eff = NW'(MAX_SERVERS);
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    efsd_cell #(
      .IDX(g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active     (NW'(g) < n_eff),
      .start_time (start_r),
      .carry_in   (chain[g]),
      .carry_out  (chain[g+1]),
      .upd        (upd)
    );
  end

  assign fin = chain[MAX_SERVERS];

  always_comb begin
    chosen    = fin.found ? fin.fidx : fin.midx;
    old_cnt   = fin.found ? fin.fcount : fin.mcount;
    act_start = fin.found ? {{(efsd_pkg::TIME_W-efsd_pkg::IN_W){1'b0}}, start_r}
                          : fin.mtime;
    end_sum   = {1'b0, act_start}
              + {{(efsd_pkg::TIME_W+1-efsd_pkg::IN_W){1'b0}}, len_r};
    time_sat  = end_sum[efsd_pkg::TIME_W];
    act_end   = time_sat ? efsd_pkg::TIME_MAX : end_sum[efsd_pkg::TIME_W-1:0];
    cnt_sat   = (old_cnt == efsd_pkg::CNT_MAX);
    new_cnt   = cnt_sat ? old_cnt : old_cnt + efsd_pkg::CNT_W'(1);
    best_take = (new_cnt > best_cnt_r) ||
                ((new_cnt == best_cnt_r) && (chosen < best_srv_r));
  end

  assign commit = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    upd.en    = commit;
    upd.idx   = chosen;
    upd.ftime = act_end;
    upd.count = new_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sweep_cnt_r    <= '0;
      server_count_r <= efsd_pkg::CFG_W'(16);
      best_srv_r     <= '0;
      best_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        server_count_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sweep_cnt_r <= '0;
            state_r     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // advance until the carry has crossed every cell
          if (sweep_cnt_r == CW'(MAX_SERVERS - 1)) begin
            state_r <= S_DONE;
          end else begin
            sweep_cnt_r <= sweep_cnt_r + CW'(1);
          end
        end
        S_DONE: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            if (best_take) begin
              best_srv_r <= chosen;
              best_cnt_r <= new_cnt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      start_r <= in_start;
      len_r   <= (in_end > in_start) ? (in_end - in_start) : '0;
    end
    if (commit) begin
      o_srv_r      <= chosen[efsd_pkg::SRV_W-1:0];
      o_start_r    <= act_start;
      o_end_r      <= act_end;
      o_best_srv_r <= best_take ? chosen[efsd_pkg::SRV_W-1:0]
                                : best_srv_r[efsd_pkg::SRV_W-1:0];
      o_best_cnt_r <= best_take ? new_cnt : best_cnt_r;
      o_sat_r      <= time_sat || cnt_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, o_sat_r, o_best_cnt_r, o_best_srv_r,
                       o_end_r, o_start_r, o_srv_r};

endmodule

// ===== sim/efsd_checker.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatcher checker
// Watches the request, result and register ports, predicts each dispatch
// from its own copy of the server table and compares results field by field.
// ----------------------------------------------------------------------------
module efsd_checker #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [63:0]                in_tdata,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [127:0]               out_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wr_en,
  input  logic [efsd_pkg::CFG_W-1:0] cfg_wr_data,
  output int                         fail_count,
  output int                         outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [efsd_pkg::CFG_W-1:0] SERVERS_AT_RESET = efsd_pkg::CFG_W'(16);

  // Result layout, last member in the lowest bits
  typedef struct packed {
    logic                        saturated;
    logic [efsd_pkg::CNT_W-1:0]  busiest_count;
    logic [efsd_pkg::SRV_W-1:0]  busiest_server;
    logic [efsd_pkg::TIME_W-1:0] actual_end;
    logic [efsd_pkg::TIME_W-1:0] run_start;
    logic [efsd_pkg::SRV_W-1:0]  assigned_server;
  } dispatch_t;

  localparam int RES_W = $bits(dispatch_t);

  logic [efsd_pkg::TIME_W-1:0] free_at    [MAX_SERVERS];
  logic [efsd_pkg::CNT_W-1:0]  jobs_taken [MAX_SERVERS];
  logic [efsd_pkg::SRV_W-1:0]  top_srv;
  logic [efsd_pkg::CNT_W-1:0]  top_jobs;
  logic [efsd_pkg::CFG_W-1:0]  srv_limit;
  dispatch_t                   due_q[$];
  dispatch_t                   got;
  dispatch_t                   want;
  int                          mismatches = 0;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatches++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, seen, wanted);
  endtask

  // Pick a server for one job and book it
  function automatic dispatch_t dispatch_job(input logic [efsd_pkg::IN_W-1:0] req_start,
                                             input logic [efsd_pkg::IN_W-1:0] req_end);
    dispatch_t                   r;
    logic [efsd_pkg::TIME_W-1:0] dur;
    logic [efsd_pkg::TIME_W-1:0] begin_at;
    logic [efsd_pkg::TIME_W-1:0] earliest;
    int                          n;
    int                          pick;
    bit                          hit;
    bit                          sat;
    dur = (req_end > req_start) ? efsd_pkg::TIME_W'(req_end - req_start) : '0;
    n = (srv_limit == 0) ? 1 : ((srv_limit > MAX_SERVERS) ? MAX_SERVERS : int'(srv_limit));
    hit = 1'b0;
    pick = 0;
    sat = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!hit && free_at[i] <= efsd_pkg::TIME_W'(req_start)) begin
        pick = i;
        hit = 1'b1;
      end
    end
    begin_at = efsd_pkg::TIME_W'(req_start);
    if (!hit) begin
      // nobody free in time: take the earliest, lowest index on ties
      earliest = free_at[0];
      for (int i = 1; i < n; i++) begin
        if (free_at[i] < earliest) begin
          earliest = free_at[i];
          pick = i;
        end
      end
      begin_at = earliest;
    end
    if (begin_at > efsd_pkg::TIME_MAX - dur) begin
      r.actual_end = efsd_pkg::TIME_MAX;
      sat = 1'b1;
    end else begin
      r.actual_end = begin_at + dur;
    end
    free_at[pick] = r.actual_end;
    if (jobs_taken[pick] == efsd_pkg::CNT_MAX) sat = 1'b1;
    else jobs_taken[pick] = jobs_taken[pick] + 1'b1;
    if (jobs_taken[pick] > top_jobs ||
        (jobs_taken[pick] == top_jobs && efsd_pkg::SRV_W'(pick) < top_srv)) begin
      top_jobs = jobs_taken[pick];
      top_srv = efsd_pkg::SRV_W'(pick);
    end
    r.assigned_server = efsd_pkg::SRV_W'(pick);
    r.run_start = begin_at;
    r.busiest_server = top_srv;
    r.busiest_count = top_jobs;
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_at[i] = '0;
        jobs_taken[i] = '0;
      end
      top_srv = '0;
      top_jobs = '0;
      srv_limit = SERVERS_AT_RESET;
      due_q.delete();
    end else begin
      if (cfg_wr_en) srv_limit = cfg_wr_data;
      // check results before booking this edge's request
      if (out_tvalid && out_tready) begin
        got = dispatch_t'(out_tdata[RES_W-1:0]);
        if (out_tdata[127:RES_W] != '0)
          report_mismatch("padding", 64'(out_tdata[127:RES_W]), 64'd0);
        if (due_q.size() == 0) begin
          report_mismatch("result without request", out_tdata[63:0], 64'd0);
        end else begin
          want = due_q.pop_front();
          if (got.assigned_server !== want.assigned_server)
            report_mismatch("assigned_server", 64'(got.assigned_server),
                            64'(want.assigned_server));
          if (got.run_start !== want.run_start)
            report_mismatch("run_start", 64'(got.run_start), 64'(want.run_start));
          if (got.actual_end !== want.actual_end)
            report_mismatch("actual_end", 64'(got.actual_end), 64'(want.actual_end));
          if (got.busiest_server !== want.busiest_server)
            report_mismatch("busiest_server", 64'(got.busiest_server),
                            64'(want.busiest_server));
          if (got.busiest_count !== want.busiest_count)
            report_mismatch("busiest_count", 64'(got.busiest_count),
                            64'(want.busiest_count));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
        end
      end
      if (in_tvalid && in_tready)
        due_q.push_back(dispatch_job(in_tdata[efsd_pkg::IN_W-1:0],
                                     in_tdata[2*efsd_pkg::IN_W-1:efsd_pkg::IN_W]));
    end
    outstanding <= due_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== sim/tb_earliest_free_server_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Earliest-free-server dispatcher testbench
// Drives job requests in phases of different server counts, first a directed
// set of corner jobs, then random job streams with random stalls on both
// sides, then a short random tail under the full server count.
// ----------------------------------------------------------------------------
module tb_earliest_free_server_dispatcher;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SERVERS   = 16;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_JOBS    = 234;
  localparam int TAIL_JOBS     = 60;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic [63:0]                 in_tdata = '0;      // start_time [31:0], end_time [63:32]
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  // assigned_server [3:0], run_start [51:4], actual_end [99:52],
  // busiest_server [103:100], busiest_count [119:104], saturated [120], zero pad
  logic [127:0]                out_tdata;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [efsd_pkg::CFG_W-1:0]  cfg_wr_data = '0;

  int                          fail_count;
  int                          outstanding;
  bit                          src_steady = 1'b0;
  bit                          sink_steady = 1'b0;
  int                          ready_hold = 0;
  int                          sink_gap;
  int                          quiet = 0;
  logic [efsd_pkg::IN_W-1:0]   cursor = '0;
  int                          step_max = 20;
  int                          len_max = 500;

  earliest_free_server_dispatcher #(
    .MAX_SERVERS(MAX_SERVERS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  efsd_checker #(
    .MAX_SERVERS(MAX_SERVERS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      sink_gap = sink_steady ? 0 : pick_gap();
      if (sink_gap > 0) begin
        out_tready <= 1'b0;
        ready_hold <= sink_gap - 1;
      end else begin
        ready_hold <= $urandom_range(0, 8);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold the request until taken; keep valid high when no gap follows
  task automatic push_job(input logic [efsd_pkg::IN_W-1:0] s,
                          input logic [efsd_pkg::IN_W-1:0] e);
    int gap;
    in_tdata <= {e, s};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write server_count
  task automatic set_servers(input logic [efsd_pkg::CFG_W-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_SERVERS + 4) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_job();
    logic [efsd_pkg::IN_W-1:0] s;
    logic [efsd_pkg::IN_W-1:0] e;
    int                        roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      // well-formed: nondecreasing start, bounded length
      cursor = cursor + $urandom_range(0, step_max);
      s = cursor;
      e = s + $urandom_range(0, len_max);
    end else if (roll < 87) begin
      cursor = cursor + $urandom_range(0, step_max);
      s = cursor;
      e = s - $urandom_range(1, 1000);
    end else if (roll < 93) begin
      s = $urandom();
      e = $urandom();
    end else if (roll < 97) begin
      s = cursor - $urandom_range(0, 5000);
      e = s + $urandom_range(0, len_max);
    end else begin
      s = '1 - $urandom_range(0, 100);
      e = '1 - $urandom_range(0, 100);
    end
    push_job(s, e);
  endtask

  initial begin
    logic [efsd_pkg::CFG_W-1:0] cfg_val;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner jobs under the reset server count
    push_job('0, '0);
    push_job('0, '1);
    push_job(32'd5, 32'd3);
    push_job('1, '1);
    push_job('1, '0);
    push_job(32'd7, 32'd9);
    // zero servers acts as one: every job queues behind server 0
    set_servers('0);
    push_job(32'd10, 32'd20);
    push_job(32'd12, 32'd15);
    // above the maximum acts as the maximum
    set_servers('1);
    push_job(32'd20, 32'd40);
    push_job(32'd20, 32'd40);
    push_job('0, '1);
    // shrink to two servers with state left in the others
    set_servers(efsd_pkg::CFG_W'(2));
    push_job(32'd100, 32'd200);
    push_job(32'd100, 32'd200);
    push_job(32'd150, 32'd140);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       cfg_val = efsd_pkg::CFG_W'(16);
        1:       cfg_val = efsd_pkg::CFG_W'(1);
        2:       cfg_val = '0;
        3:       cfg_val = '1;
        4:       cfg_val = efsd_pkg::CFG_W'(17);
        default: cfg_val = efsd_pkg::CFG_W'($urandom_range(2, 15));
      endcase
      set_servers(cfg_val);
      case ($urandom_range(0, 2))
        0:       step_max = 2;
        1:       step_max = 20;
        default: step_max = 200;
      endcase
      case ($urandom_range(0, 2))
        0:       len_max = 50;
        1:       len_max = 500;
        default: len_max = 5000;
      endcase
      src_steady <= ($urandom_range(0, 3) == 0);
      sink_steady <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_JOBS; k++) random_job();
    end

    set_servers(efsd_pkg::CFG_W'(16));
    src_steady <= 1'b0;
    sink_steady <= 1'b0;
    for (int k = 0; k < TAIL_JOBS; k++) random_job();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_SERVERS + 8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== earliest_free_server_dispatcher.f =====
rtl/core/efsd_pkg.sv
rtl/core/efsd_cell.sv
rtl/core/earliest_free_server_dispatcher.sv
sim/efsd_checker.sv
sim/tb_earliest_free_server_dispatcher.sv
